/* rtl/heightfield_bilinear_sample_unit_macros.svh */
// assertion macros for the checker file
`ifndef HEIGHTFIELD_BILINEAR_SAMPLE_UNIT_MACROS_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hbs_pkg.sv */
// shared widths, register indexes and control types of the heightfield sampler
package hbs_pkg;

	localparam int HGT_W     = 16;  // stored height
	localparam int CELL_W    = 6;   // write-mode row / column
	localparam int SMP_W     = 14;  // fixed point sample coordinate
	localparam int CFG_W     = 7;   // size registers
	localparam int CFG_IDX_W = 2;   // configuration register index
	localparam int CRD_W     = 11;  // integer grid coordinate incl. the +1 corner

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;     // update the accumulator this cycle
		logic fresh;  // start a new sum instead of adding to the old one
	} mac_ctl_t;

endpackage

/* rtl/hbs_grid_ram.sv */
// single-port height grid memory with registered read data
module hbs_grid_ram #(
	parameter int DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(DEPTH)-1:0]              addr,
	input  logic signed [hbs_pkg::HGT_W-1:0]      wdata,
	output logic signed [hbs_pkg::HGT_W-1:0]      rdata
);

	logic signed [hbs_pkg::HGT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/hbs_mac.sv */
// shared multiply-accumulate unit: acc = (fresh ? 0 : acc) + weight * operand
module hbs_mac #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                                              clk,
	input  hbs_pkg::mac_ctl_t                                 ctl,
	input  logic [FRACTION_BITS:0]                            weight,
	input  logic signed [hbs_pkg::HGT_W+FRACTION_BITS:0]      operand,
	output logic signed [hbs_pkg::HGT_W+2*FRACTION_BITS+1:0]  acc
);

	localparam int OPW  = hbs_pkg::HGT_W + FRACTION_BITS + 1;
	localparam int ACCW = hbs_pkg::HGT_W + 2 * FRACTION_BITS + 2;
	localparam int PW   = FRACTION_BITS + 2 + OPW;

	logic signed [FRACTION_BITS+1:0] weight_s;
	logic signed [PW-1:0]            prod;
	logic signed [ACCW-1:0]          base;

	// weight is unsigned, give it a zero sign bit
	assign weight_s = {1'b0, weight};
	assign prod     = weight_s * operand;
	assign base     = ctl.fresh ? '0 : acc;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc <= base + ACCW'(prod);
		end
	end

endmodule

/* rtl/heightfield_bilinear_sample_unit.sv */
// top level: bilinear sampler over a stored grid of signed heights
//
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// item in   | start, busy            | mode, cell_row, cell_col, cell_height,
//           |                        | sample_x, sample_y
// result    | done (one-cycle pulse) | sample_value, out_of_range
// config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// a write item: the cell is written at the accept edge and done pulses in the
// next cycle, so writes may follow each other every cycle.
// an out-of-range sample also answers in the next cycle without going busy.
// an in-range sample goes busy after accept until its result: four corner reads
// through the single memory port, overlapped with six passes of the shared
// multiply-accumulate unit, then rounding.
// after reset the grid is cleared one cell per cycle with busy high; cfg_ready
// is always high. done cannot be stalled by the receiver.
module heightfield_bilinear_sample_unit #(
	parameter int GRID_COLS     = 64,
	parameter int GRID_ROWS     = 64,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// item transaction
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   mode,
	input  logic [hbs_pkg::CELL_W-1:0]             cell_row,
	input  logic [hbs_pkg::CELL_W-1:0]             cell_col,
	input  logic signed [hbs_pkg::HGT_W-1:0]       cell_height,
	input  logic [hbs_pkg::SMP_W-1:0]              sample_x,
	input  logic [hbs_pkg::SMP_W-1:0]              sample_y,
	// result transaction
	output logic                                   done,
	output logic signed [hbs_pkg::HGT_W-1:0]       sample_value,
	output logic                                   out_of_range,
	// configuration transaction
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [hbs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [hbs_pkg::CFG_W-1:0]              cfg_data
);

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int HW    = hbs_pkg::HGT_W;
	localparam int CW    = hbs_pkg::CRD_W;
	localparam int WW    = FRACTION_BITS + 1;
	localparam int OPW   = HW + FRACTION_BITS + 1;
	localparam int ACCW  = HW + 2 * FRACTION_BITS + 2;
	localparam int XW    = hbs_pkg::SMP_W + FRACTION_BITS;

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	// steps of one sample: corner reads, then the multiply-accumulate passes
	localparam logic [2:0] STP_RD00   = 3'd0;  // read (y0,x0)
	localparam logic [2:0] STP_RD01   = 3'd1;  // read (y0,x1), acc  = (S-t)*g00
	localparam logic [2:0] STP_RD10   = 3'd2;  // read (y1,x0), acc += t*g01
	localparam logic [2:0] STP_RD11   = 3'd3;  // read (y1,x1), keep row 0, acc = (S-t)*g10
	localparam logic [2:0] STP_ROW1   = 3'd4;  // acc += t*g11
	localparam logic [2:0] STP_VERT0  = 3'd5;  // keep row 1, acc = (S-u)*row0
	localparam logic [2:0] STP_VERT1  = 3'd6;  // acc += u*row1
	localparam logic [2:0] STP_ROUND  = 3'd7;  // round and deliver

	localparam logic [WW-1:0]   SCALE = WW'(1) << FRACTION_BITS;
	localparam logic [ACCW-1:0] HALF  = ACCW'(1) << (2 * FRACTION_BITS - 1);

	logic [1:0]                state_q;
	logic [2:0]                stp_q;
	logic [AW-1:0]             clr_cnt_q;
	logic [hbs_pkg::CFG_W-1:0] columns_q;
	logic [hbs_pkg::CFG_W-1:0] rows_q;
	logic                      done_q;

	// sample operands held for the whole run
	logic [CW-1:0]             x0_q, x1_q, y0_q, y1_q;
	logic [FRACTION_BITS-1:0]  t_q, u_q;
	logic signed [OPW-1:0]     row_sum_q;
	logic signed [HW-1:0]      value_q;
	logic                      oor_q;

	logic                      accept;
	logic [XW-1:0]             x_ext, y_ext;
	logic [CW-1:0]             x0_in, x1_in, y0_in, y1_in;
	logic [FRACTION_BITS-1:0]  t_in, u_in;
	logic [CW-1:0]             col_lim, row_lim;
	logic                      oor_in;
	logic                      wr_ok;

	logic                      mem_we;
	logic [AW-1:0]             mem_addr;
	logic signed [HW-1:0]      mem_wdata;
	logic signed [HW-1:0]      mem_rdata;
	logic [CW-1:0]             rd_row, rd_col;

	hbs_pkg::mac_ctl_t         mac_ctl;
	logic [WW-1:0]             mac_weight;
	logic signed [OPW-1:0]     mac_op;
	logic signed [ACCW-1:0]    mac_acc;
	logic signed [ACCW-1:0]    rounded;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// split the coordinates into cell index and fraction
	assign x_ext = {FRACTION_BITS'(0), sample_x};
	assign y_ext = {FRACTION_BITS'(0), sample_y};
	assign x0_in = CW'(x_ext >> FRACTION_BITS);
	assign y0_in = CW'(y_ext >> FRACTION_BITS);
	assign t_in  = x_ext[FRACTION_BITS-1:0];
	assign u_in  = y_ext[FRACTION_BITS-1:0];
	// the far corner only moves when there is a fraction
	assign x1_in = x0_in + CW'(t_in != '0);
	assign y1_in = y0_in + CW'(u_in != '0);

	// size registers above the store size act as the store size
	assign col_lim = (CW'(columns_q) > CW'(GRID_COLS)) ? CW'(GRID_COLS) : CW'(columns_q);
	assign row_lim = (CW'(rows_q) > CW'(GRID_ROWS)) ? CW'(GRID_ROWS) : CW'(rows_q);
	assign oor_in  = (x1_in >= col_lim) || (y1_in >= row_lim);

	// writes outside the store are dropped
	assign wr_ok = (CW'(cell_row) < CW'(GRID_ROWS)) && (CW'(cell_col) < CW'(GRID_COLS));

	// corner select: step bit 1 picks the row, bit 0 the column
	assign rd_row = stp_q[1] ? y1_q : y0_q;
	assign rd_col = stp_q[0] ? x1_q : x0_q;

	// one memory port shared by clearing, cell writes and corner reads
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = cell_height;
		mem_addr  = AW'(rd_row) * AW'(GRID_COLS) + AW'(rd_col);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				mem_addr  = clr_cnt_q;
			end
			ST_IDLE: begin
				mem_we   = accept && !mode && wr_ok;
				mem_addr = AW'(cell_row) * AW'(GRID_COLS) + AW'(cell_col);
			end
			default: begin
			end
		endcase
	end

	hbs_grid_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// weight and operand of the shared unit per step
	always_comb begin
		mac_ctl.en    = 1'b0;
		mac_ctl.fresh = 1'b0;
		mac_weight    = '0;
		mac_op        = {{(OPW-HW){mem_rdata[HW-1]}}, mem_rdata};
		if (state_q == ST_RUN) begin
			case (stp_q)
				STP_RD01, STP_RD11: begin
					mac_ctl.en    = 1'b1;
					mac_ctl.fresh = 1'b1;
					mac_weight    = SCALE - WW'(t_q);
				end
				STP_RD10, STP_ROW1: begin
					mac_ctl.en = 1'b1;
					mac_weight = WW'(t_q);
				end
				STP_VERT0: begin
					mac_ctl.en    = 1'b1;
					mac_ctl.fresh = 1'b1;
					mac_weight    = SCALE - WW'(u_q);
					mac_op        = row_sum_q;
				end
				STP_VERT1: begin
					mac_ctl.en = 1'b1;
					mac_weight = WW'(u_q);
					mac_op     = row_sum_q;
				end
				default: begin
				end
			endcase
		end
	end

	hbs_mac #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.weight  (mac_weight),
		.operand (mac_op),
		.acc     (mac_acc)
	);

	// round to nearest, ties upward: add one half, then floor by arithmetic shift
	assign rounded = (mac_acc + HALF) >>> (2 * FRACTION_BITS);

	// control: sequencer, clearing sweep, size registers, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			stp_q     <= STP_RD00;
			clr_cnt_q <= '0;
			columns_q <= hbs_pkg::CFG_SIZE_RESET;
			rows_q    <= hbs_pkg::CFG_SIZE_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// unknown indexes are ignored
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == hbs_pkg::REG_COLUMNS) begin
					columns_q <= cfg_data;
				end else if (cfg_index == hbs_pkg::REG_ROWS) begin
					rows_q <= cfg_data;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						// writes and rejected samples answer right away
						if (!mode || oor_in) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RUN;
							stp_q   <= STP_RD00;
						end
					end
				end
				ST_RUN: begin
					stp_q <= stp_q + 3'd1;
					if (stp_q == STP_ROUND) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			x0_q    <= x0_in;
			x1_q    <= x1_in;
			y0_q    <= y0_in;
			y1_q    <= y1_in;
			t_q     <= t_in;
			u_q     <= u_in;
			value_q <= '0;
			oor_q   <= mode && oor_in;
		end
		// park the finished row sum before the accumulator is reused
		if (state_q == ST_RUN && (stp_q == STP_RD11 || stp_q == STP_VERT0)) begin
			row_sum_q <= OPW'(mac_acc);
		end
		if (state_q == ST_RUN && stp_q == STP_ROUND) begin
			value_q <= HW'(rounded);
			oor_q   <= 1'b0;
		end
	end

	assign done         = done_q;
	assign sample_value = value_q;
	assign out_of_range = oor_q;

endmodule

/* rtl/hbs_checker.sv */
// port-level checker for the heightfield sampler and its bind
`include "heightfield_bilinear_sample_unit_macros.svh"

module hbs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               mode,
	input logic                               done,
	input logic signed [hbs_pkg::HGT_W-1:0]   sample_value,
	input logic                               out_of_range
);

	// a write transaction answers next cycle with a clean zero result
	`HBS_ASSERT_NEXT(a_write_result, clk, arst_n, start && !busy && !mode,
		done && !out_of_range && sample_value == '0, "write item without clean result")

	// a sample transaction either answers at once as out of range or keeps the block busy
	`HBS_ASSERT_NEXT(a_sample_progress, clk, arst_n, start && !busy && mode,
		(done && out_of_range) || (busy && !done), "sample item neither rejected nor running")

	// an out-of-range result carries a zero value
	`HBS_ASSERT_NOW(a_oor_zero, clk, arst_n, done && out_of_range,
		sample_value == '0, "out-of-range result with nonzero value")

	// every result follows an accepted transaction or the end of a busy run
	`HBS_ASSERT_NOW(a_no_spurious, clk, arst_n, done,
		$past(busy) || $past(start && !busy), "result without a transaction")

endmodule

bind heightfield_bilinear_sample_unit hbs_checker u_hbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.done         (done),
	.sample_value (sample_value),
	.out_of_range (out_of_range)
);

/* tb/tb_heightfield_bilinear_sample_unit.sv */
// self-checking testbench for the heightfield bilinear sampler
`timescale 1ns / 1ps

module tb_heightfield_bilinear_sample_unit;

	// grid geometry and fixed point format of the instance under test
	localparam int GRID_DIM = 64;
	localparam int FRAC_BITS = 8;
	localparam longint SCALE = longint'(1) << FRAC_BITS;
	localparam int COORD_MAX = (1 << hbs_pkg::SMP_W) - 1;

	// item kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// register indexes the block does not decode, writes there must be dropped
	localparam logic [hbs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [hbs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// cycles to let pass once the last result has come
	localparam int SETTLE_CYCLES = 16;

	// field types, also used to size random values
	typedef logic [hbs_pkg::CELL_W-1:0] cell_idx_t;
	typedef logic signed [hbs_pkg::HGT_W-1:0] height_t;
	typedef logic [hbs_pkg::SMP_W-1:0] coord_t;
	typedef logic [hbs_pkg::CFG_W-1:0] cfg_word_t;

	typedef struct {
		logic mode;
		logic [hbs_pkg::CELL_W-1:0] row;
		logic [hbs_pkg::CELL_W-1:0] col;
		logic signed [hbs_pkg::HGT_W-1:0] height;
		logic [hbs_pkg::SMP_W-1:0] sx;
		logic [hbs_pkg::SMP_W-1:0] sy;
	} height_item_t;

	typedef struct {
		logic signed [hbs_pkg::HGT_W-1:0] value;
		logic oor;
	} sample_result_t;

	// all inputs known from time zero, reset held from the start
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = MODE_WRITE;
	logic [hbs_pkg::CELL_W-1:0] cell_row = '0;
	logic [hbs_pkg::CELL_W-1:0] cell_col = '0;
	logic signed [hbs_pkg::HGT_W-1:0] cell_height = '0;
	logic [hbs_pkg::SMP_W-1:0] sample_x = '0;
	logic [hbs_pkg::SMP_W-1:0] sample_y = '0;
	logic done;
	logic signed [hbs_pkg::HGT_W-1:0] sample_value;
	logic out_of_range;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index = hbs_pkg::REG_COLUMNS;
	logic [hbs_pkg::CFG_W-1:0] cfg_data = '0;

	// shadow copy of the block state, updated as each transaction is accepted
	logic signed [hbs_pkg::HGT_W-1:0] grid_model [GRID_DIM][GRID_DIM];
	logic [hbs_pkg::CFG_W-1:0] cols_setting;
	logic [hbs_pkg::CFG_W-1:0] rows_setting;

	// expected results in order of acceptance
	sample_result_t pending_results[$];
	int mismatch_count = 0;

	// sender idling alternates between random gaps and back-to-back stretches
	bit back_to_back = 1'b0;

	heightfield_bilinear_sample_unit #(
		.GRID_COLS(GRID_DIM),
		.GRID_ROWS(GRID_DIM),
		.FRACTION_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cell_height(cell_height),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.done(done),
		.sample_value(sample_value),
		.out_of_range(out_of_range),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// expected result of one item, writes also update the shadow grid
	function automatic sample_result_t predict_item(input height_item_t it);
		sample_result_t r;
		int x0, y0, x1, y1, col_lim, row_lim;
		longint t, u, acc, rounded;
		r.value = '0;
		r.oor = 1'b0;
		if (it.mode == MODE_WRITE) begin
			// row and column are 6 bits, every write lands in the 64x64 store
			grid_model[it.row][it.col] = it.height;
			return r;
		end
		x0 = int'(it.sx >> FRAC_BITS);
		y0 = int'(it.sy >> FRAC_BITS);
		t = longint'(it.sx[FRAC_BITS-1:0]);
		u = longint'(it.sy[FRAC_BITS-1:0]);
		// the far corner is only needed when there is a fraction
		x1 = x0 + int'(t != 0);
		y1 = y0 + int'(u != 0);
		// size registers above the store size saturate at the store size
		col_lim = (int'(cols_setting) > GRID_DIM) ? GRID_DIM : int'(cols_setting);
		row_lim = (int'(rows_setting) > GRID_DIM) ? GRID_DIM : int'(rows_setting);
		if (x1 >= col_lim || y1 >= row_lim) begin
			r.oor = 1'b1;
			return r;
		end
		acc = (SCALE - t) * (SCALE - u) * longint'(grid_model[cell_idx_t'(y0)][cell_idx_t'(x0)])
			+ t * (SCALE - u) * longint'(grid_model[cell_idx_t'(y0)][cell_idx_t'(x1)])
			+ t * u * longint'(grid_model[cell_idx_t'(y1)][cell_idx_t'(x1)])
			+ (SCALE - t) * u * longint'(grid_model[cell_idx_t'(y1)][cell_idx_t'(x0)]);
		// round half toward plus infinity by adding one half and flooring
		rounded = (acc + (SCALE * SCALE / 2)) >>> (2 * FRAC_BITS);
		if (rounded > 32767)
			rounded = 32767;
		if (rounded < -32768)
			rounded = -32768;
		r.value = rounded[hbs_pkg::HGT_W-1:0];
		return r;
	endfunction

	// write item, the unused sample fields carry random bits
	function automatic height_item_t make_write(input int row, input int col, input int height);
		height_item_t it;
		it.mode = MODE_WRITE;
		it.row = cell_idx_t'(row);
		it.col = cell_idx_t'(col);
		it.height = height_t'(height);
		it.sx = coord_t'($urandom);
		it.sy = coord_t'($urandom);
		return it;
	endfunction

	// sample item, the unused write fields carry random bits
	function automatic height_item_t make_sample(input int x, input int y);
		height_item_t it;
		it.mode = MODE_SAMPLE;
		it.row = cell_idx_t'($urandom);
		it.col = cell_idx_t'($urandom);
		it.height = height_t'($urandom);
		it.sx = coord_t'(x);
		it.sy = coord_t'(y);
		return it;
	endfunction

	task automatic log_mismatch(input string what, input int exp_v, input int got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
	endtask

	// one item transaction, called at a rising edge; start is left high so a
	// following item with no gap goes out without a low cycle in between
	task automatic issue_item(input height_item_t it);
		int gap;
		if ($urandom_range(0, 31) == 0)
			back_to_back = !back_to_back;
		gap = back_to_back ? 0 : int'($urandom_range(0, 15));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= it.mode;
		cell_row <= it.row;
		cell_col <= it.col;
		cell_height <= it.height;
		sample_x <= it.sx;
		sample_y <= it.sy;
		// busy as sampled at the edge decides acceptance
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_item(it));
	endtask

	// stop sending and wait until the block has answered everything
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one configuration transaction, only issued while the block is idle
	task automatic write_reg(input logic [hbs_pkg::CFG_IDX_W-1:0] idx,
			input logic [hbs_pkg::CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hbs_pkg::REG_COLUMNS: cols_setting = data;
			hbs_pkg::REG_ROWS: rows_setting = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// every done pulse is matched against the oldest expectation
	always @(posedge clk) begin : result_check
		sample_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				log_mismatch("unexpected result", 0, int'(sample_value));
			end else begin
				want = pending_results.pop_front();
				if (sample_value !== want.value)
					log_mismatch("sample_value", int'(want.value), int'(sample_value));
				if (out_of_range !== want.oor)
					log_mismatch("out_of_range", int'(want.oor), int'(out_of_range));
			end
		end
	end

	// full-scale heights at the corners, rounding ties and the grid edges
	task automatic test_directed_corners();
		issue_item(make_sample(0, 0));
		issue_item(make_write(0, 0, 32767));
		issue_item(make_write(0, 1, -32768));
		issue_item(make_write(1, 0, -32768));
		issue_item(make_write(1, 1, 32767));
		issue_item(make_sample(0, 0));
		// halfway between +max and -max is -0.5, a tie that must round up to 0
		issue_item(make_sample('h080, 0));
		issue_item(make_sample('h080, 'h080));
		issue_item(make_sample('h0FF, 'h001));
		issue_item(make_write(63, 63, 12345));
		issue_item(make_write(63, 62, -1));
		issue_item(make_write(62, 63, -7));
		// exactly size-1 is inside, one step beyond is outside
		issue_item(make_sample(63 << FRAC_BITS, 63 << FRAC_BITS));
		issue_item(make_sample((63 << FRAC_BITS) + 1, 0));
		issue_item(make_sample(0, (63 << FRAC_BITS) + 1));
		issue_item(make_sample((62 << FRAC_BITS) | 'hFF, (62 << FRAC_BITS) | 'hFF));
		issue_item(make_sample(COORD_MAX, COORD_MAX));
		issue_item(make_sample(0, COORD_MAX));
		issue_item(make_write(63, 0, -32768));
		issue_item(make_sample(1 << FRAC_BITS, (62 << FRAC_BITS) | 'h80));
		drain_results();
	endtask

	// size registers at zero, one, two, saturated and unknown indexes
	task automatic test_size_registers();
		write_reg(hbs_pkg::REG_COLUMNS, 0);
		issue_item(make_sample(0, 0));
		drain_results();
		// a size of one admits coordinate zero only
		write_reg(hbs_pkg::REG_COLUMNS, 1);
		write_reg(hbs_pkg::REG_ROWS, 1);
		issue_item(make_sample(0, 0));
		issue_item(make_sample(1, 0));
		issue_item(make_sample(0, 1));
		drain_results();
		// all-ones sizes saturate at the store size
		write_reg(hbs_pkg::REG_COLUMNS, 127);
		write_reg(hbs_pkg::REG_ROWS, 127);
		issue_item(make_sample(63 << FRAC_BITS, 63 << FRAC_BITS));
		issue_item(make_sample((63 << FRAC_BITS) + 1, 0));
		drain_results();
		// writes to undecoded indexes leave the sizes alone
		write_reg(REG_SPARE_2, 0);
		write_reg(REG_SPARE_3, 0);
		issue_item(make_sample(63 << FRAC_BITS, 63 << FRAC_BITS));
		drain_results();
		write_reg(hbs_pkg::REG_ROWS, 0);
		issue_item(make_sample(0, 0));
		drain_results();
		write_reg(hbs_pkg::REG_COLUMNS, 2);
		write_reg(hbs_pkg::REG_ROWS, 2);
		issue_item(make_sample(1 << FRAC_BITS, 1 << FRAC_BITS));
		issue_item(make_sample((1 << FRAC_BITS) + 1, 0));
		issue_item(make_sample('h080, 'h080));
		drain_results();
	endtask

	// random traffic focused on a square window so samples see written cells;
	// a tenth of the items are noise with every field random
	task automatic run_random_phase(input int n_items, input int win_row, input int win_col,
			input int win_span);
		height_item_t it;
		int pick, col_lim, row_lim, x_hi, y_hi, row_hi, col_hi;
		col_lim = (int'(cols_setting) > GRID_DIM) ? GRID_DIM : int'(cols_setting);
		row_lim = (int'(rows_setting) > GRID_DIM) ? GRID_DIM : int'(rows_setting);
		row_hi = (win_row + win_span - 1 > GRID_DIM - 1) ? GRID_DIM - 1 : win_row + win_span - 1;
		col_hi = (win_col + win_span - 1 > GRID_DIM - 1) ? GRID_DIM - 1 : win_col + win_span - 1;
		// highest in-range coordinate of the window, integer part at most size-1
		x_hi = ((col_hi > col_lim - 1) ? col_lim - 1 : col_hi) << FRAC_BITS;
		y_hi = ((row_hi > row_lim - 1) ? row_lim - 1 : row_hi) << FRAC_BITS;
		repeat (n_items) begin
			pick = int'($urandom_range(0, 9));
			if (pick < 4) begin
				it = make_write($urandom_range(win_row, row_hi), $urandom_range(win_col, col_hi),
					$urandom);
			end else if (pick < 9) begin
				it = make_sample($urandom_range(win_col << FRAC_BITS, x_hi),
					$urandom_range(win_row << FRAC_BITS, y_hi));
				// now and then land on a grid line
				if ($urandom_range(0, 7) == 0)
					it.sx[FRAC_BITS-1:0] = '0;
				if ($urandom_range(0, 7) == 0)
					it.sy[FRAC_BITS-1:0] = '0;
			end else begin
				it = make_sample($urandom, $urandom);
				it.mode = ($urandom_range(0, 1) == 1) ? MODE_SAMPLE : MODE_WRITE;
			end
			issue_item(it);
		end
	endtask

	// small grids, the whole grid in use is the window
	task automatic test_random_small_grids();
		repeat (4) begin
			write_reg(hbs_pkg::REG_COLUMNS, cfg_word_t'($urandom_range(2, 8)));
			write_reg(hbs_pkg::REG_ROWS, cfg_word_t'($urandom_range(2, 8)));
			run_random_phase(80, 0, 0, 8);
			drain_results();
		end
	endtask

	// large and saturated sizes, a random window somewhere in the grid
	task automatic test_random_full_grid();
		int col_lim, row_lim;
		repeat (4) begin
			write_reg(hbs_pkg::REG_COLUMNS,
				cfg_word_t'(($urandom_range(0, 3) == 0) ? 127 : $urandom_range(16, 64)));
			write_reg(hbs_pkg::REG_ROWS,
				cfg_word_t'(($urandom_range(0, 3) == 0) ? 127 : $urandom_range(16, 64)));
			col_lim = (int'(cols_setting) > GRID_DIM) ? GRID_DIM : int'(cols_setting);
			row_lim = (int'(rows_setting) > GRID_DIM) ? GRID_DIM : int'(rows_setting);
			run_random_phase(150, $urandom_range(0, row_lim - 1), $urandom_range(0, col_lim - 1),
				12);
			drain_results();
		end
	endtask

	initial begin
		// state after reset: heights zero, both sizes at their reset value
		foreach (grid_model[r, c])
			grid_model[r][c] = '0;
		cols_setting = hbs_pkg::CFG_SIZE_RESET;
		rows_setting = hbs_pkg::CFG_SIZE_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// the grid clearing pass after reset shows up as busy in the first item
		test_directed_corners();
		test_size_registers();
		test_random_small_grids();
		test_random_full_grid();
		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
